// ----- sv/gsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types, constants and tables of the goal-seek controller pipeline.
// ----------------------------------------------------------------------------
package gsc_pkg;

  // number of vectoring CORDIC iterations, 8 to 24
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;

  // root bits of the two square roots
  localparam int S_ROOT_BITS = 15;
  localparam int D_ROOT_BITS = 32;

  // angle constants
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [20:0] PI_Q12      = 21'sd12868;
  localparam logic signed [20:0] HALF_PI_Q12 = 21'sd6434;
  localparam logic [63:0]        ONE_SQ_Q28  = 64'd268435456;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_ANGULAR_GAIN = 3'd2,
    REG_LINEAR_GAIN  = 3'd3,
    REG_GOAL_RADIUS  = 3'd4
  } reg_idx_e;

  // arctangent of 2^-i in Q2.30
  localparam logic signed [34:0] ATAN_Q30 [ATAN_LEN] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
    35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
    35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
    35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
    35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
    35'sd1024,      35'sd512,       35'sd256,       35'sd128
  };

  // partial square root and remainder
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // vectoring rotation state
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [34:0] z;
    logic               zero;
  } cordic_t;

endpackage

// ----- sv/unicycle_goal_seek_controller_unit.sv -----
// ----------------------------------------------------------------------------
// unicycle_goal_seek_controller_unit
// Proportional go-to-goal controller for a unicycle robot, fully pipelined.
// ----------------------------------------------------------------------------
// One pose transfer is taken every cycle while the output side keeps up.
// The depth is set by the 32-cell distance square root and by the heading
// path of 15 root cells, the CORDIC front end and the CORDIC cells. Every
// cell shares one advance enable, so the whole row, input included, stalls
// for as long as a waiting result is not taken.
module unicycle_goal_seek_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] linear_velocity_o,
  output logic signed [31:0] angular_velocity_o,
  output logic               reversing_o,
  output logic               goal_reached_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import gsc_pkg::*;

  // stage numbering
  localparam int B_END  = 3 + CORDIC_STAGES;
  localparam int S_END  = 1 + S_ROOT_BITS;
  localparam int H_END  = S_END + 3 + CORDIC_STAGES;
  localparam int D_END  = 3 + D_ROOT_BITS;
  localparam int JS     = ((D_END > H_END) ? D_END : H_END) + 1;
  localparam int LAST   = JS + 3;
  localparam int L_B    = JS - B_END;
  localparam int L_H    = JS - H_END;
  localparam int L_D    = JS - D_END;
  localparam int L_W    = S_END;

  // configuration registers
  logic signed [31:0] goal_x_q, goal_y_q;
  logic [15:0]        ang_gain_q, lin_gain_q;
  logic [30:0]        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q   <= '0;
      goal_y_q   <= '0;
      ang_gain_q <= 16'd2662;
      lin_gain_q <= 16'd410;
      radius_q   <= 31'd6554;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GOAL_X:       goal_x_q   <= cfg_data_i;
        REG_GOAL_Y:       goal_y_q   <= cfg_data_i;
        REG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i[15:0];
        REG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i[15:0];
        REG_GOAL_RADIUS:  radius_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // valid row and global advance
  logic [LAST:0] vld_q;
  logic          adv;

  assign adv        = !vld_q[LAST] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  // stage 0: offsets to goal, clamped w, sign of z
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] w_d, w_q;
  logic [1:0]         qsgn_q;

  always_comb begin
    w_d = quat_w_i;
    if (quat_w_i > 16'sd16384)  w_d = 16'sd16384;
    if (quat_w_i < -16'sd16384) w_d = -16'sd16384;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q   <= 33'(goal_x_q) - 33'(pos_x_i);
      dy_q   <= 33'(goal_y_q) - 33'(pos_y_i);
      w_q    <= w_d;
      qsgn_q <= {quat_z_i < 16'sd0, quat_z_i > 16'sd0};
    end
  end

  // distance front end: magnitudes, squares, sum
  logic [32:0] adx, ady;
  logic        sh_d;
  logic [31:0] ax_q, ay_q;
  logic        sh_q;
  logic [63:0] sqx_q, sqy_q, sum_q;
  logic [28:0] ww_q;

  always_comb begin
    adx  = (dx_q < 33'sd0) ? 33'(-dx_q) : 33'(dx_q);
    ady  = (dy_q < 33'sd0) ? 33'(-dy_q) : 33'(dy_q);
    sh_d = adx[32] | adx[31] | ady[32] | ady[31];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q  <= sh_d ? adx[32:1] : adx[31:0];
      ay_q  <= sh_d ? ady[32:1] : ady[31:0];
      sh_q  <= sh_d;
      ww_q  <= 29'(32'(w_q * w_q));
      sqx_q <= 64'(ax_q) * 64'(ax_q);
      sqy_q <= 64'(ay_q) * 64'(ay_q);
      sum_q <= sqx_q + sqy_q;
    end
  end

  // distance root cells
  sqrt_t d_row [D_ROOT_BITS+1];
  assign d_row[0] = '{rem: sum_q, root: '0};

  for (genvar k = 0; k < D_ROOT_BITS; k++) begin : g_dist
    gsc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .idx_i  (5'(D_ROOT_BITS - 1 - k)),
      .sqrt_i (d_row[k]),
      .sqrt_o (d_row[k+1])
    );
  end

  // sine part root cells, sqrt(1 - w*w)
  sqrt_t s_row [S_ROOT_BITS+1];
  assign s_row[0] = '{rem: ONE_SQ_Q28 - 64'(ww_q), root: '0};

  for (genvar k = 0; k < S_ROOT_BITS; k++) begin : g_sine
    gsc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .idx_i  (5'(S_ROOT_BITS - 1 - k)),
      .sqrt_i (s_row[k]),
      .sqrt_o (s_row[k+1])
    );
  end

  // w waits for the sine root
  logic signed [15:0] w_dly_q [L_W];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_dly_q[0] <= w_q;
      for (int i = 1; i < L_W; i++) w_dly_q[i] <= w_dly_q[i-1];
    end
  end

  // bearing CORDIC
  cordic_t b_row [CORDIC_STAGES+1];

  gsc_atan_front u_bear_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (36'(dx_q)),
    .y_i   (36'(dy_q)),
    .vec_o (b_row[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_bear
    gsc_cordic_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .idx_i (5'(k)),
      .vec_i (b_row[k]),
      .vec_o (b_row[k+1])
    );
  end

  // half-heading CORDIC, atan2(s, w)
  cordic_t h_row [CORDIC_STAGES+1];

  gsc_atan_front u_head_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (36'(w_dly_q[L_W-1])),
    .y_i   ({20'd0, s_row[S_ROOT_BITS].root[15:0]}),
    .vec_o (h_row[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_head
    gsc_cordic_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .idx_i (5'(k)),
      .vec_i (h_row[k]),
      .vec_o (h_row[k+1])
    );
  end

  // alignment delay lines up to the join stage
  logic signed [34:0] zb_dly_q [L_B];
  logic signed [34:0] zh_dly_q [L_H];
  logic [31:0]        rt_dly_q [L_D];
  logic               sh_dly_q [JS-1];
  logic [1:0]         qs_dly_q [JS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zb_dly_q[0] <= b_row[CORDIC_STAGES].zero ? 35'sd0 : b_row[CORDIC_STAGES].z;
      for (int i = 1; i < L_B; i++) zb_dly_q[i] <= zb_dly_q[i-1];
      zh_dly_q[0] <= h_row[CORDIC_STAGES].zero ? 35'sd0 : h_row[CORDIC_STAGES].z;
      for (int i = 1; i < L_H; i++) zh_dly_q[i] <= zh_dly_q[i-1];
      rt_dly_q[0] <= d_row[D_ROOT_BITS].root;
      for (int i = 1; i < L_D; i++) rt_dly_q[i] <= rt_dly_q[i-1];
      sh_dly_q[0] <= sh_q;
      for (int i = 1; i < JS - 1; i++) sh_dly_q[i] <= sh_dly_q[i-1];
      qs_dly_q[0] <= qsgn_q;
      for (int i = 1; i < JS; i++) qs_dly_q[i] <= qs_dly_q[i-1];
    end
  end

  // join: heading error and reverse decision
  logic signed [35:0] bsum, hsum;
  logic signed [20:0] bearing, half, theta, err, err_adj;
  logic               rev_d;
  logic signed [20:0] err_q;
  logic               rev_q, rev2_q;
  logic [32:0]        dist_q, dist2_q;

  always_comb begin
    bsum    = 36'(zb_dly_q[L_B-1]) + 36'sd131072;
    hsum    = 36'(zh_dly_q[L_H-1]) + 36'sd131072;
    bearing = 21'($signed(bsum[35:18]));
    half    = 21'($signed(hsum[35:18]));
    case (qs_dly_q[JS-1])
      2'b01:   theta = half <<< 1;
      2'b10:   theta = -(half <<< 1);
      default: theta = 21'sd0;
    endcase
    err     = bearing - theta;
    rev_d   = (err > HALF_PI_Q12) || (err < -HALF_PI_Q12);
    err_adj = err;
    if (err > HALF_PI_Q12)       err_adj = err - PI_Q12;
    else if (err < -HALF_PI_Q12) err_adj = err + PI_Q12;
  end

  // gain products
  logic signed [37:0] angp_q;
  logic [48:0]        linp_q;
  logic               reached_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err_q     <= err_adj;
      rev_q     <= rev_d;
      dist_q    <= sh_dly_q[JS-2] ? {rt_dly_q[L_D-1], 1'b0} : {1'b0, rt_dly_q[L_D-1]};
      angp_q    <= 38'($signed({1'b0, ang_gain_q}) * err_q);
      linp_q    <= 49'(lin_gain_q) * 49'(dist_q);
      rev2_q    <= rev_q;
      dist2_q   <= dist_q;
    end
  end

  // rounding, sign and linear saturation into the output registers
  logic signed [37:0] ang_r;
  logic [49:0]        lin_sum;
  logic signed [38:0] lin_s;
  logic signed [31:0] lin_sat;
  logic signed [31:0] lin_out_q, ang_out_q;
  logic               rev_out_q;

  always_comb begin
    ang_r   = (angp_q + 38'sd128) >>> 8;
    lin_sum = 50'(linp_q) + 50'd2048;
    lin_s   = rev2_q ? -$signed({1'b0, lin_sum[49:12]}) : $signed({1'b0, lin_sum[49:12]});
    if (lin_s > 39'sd2147483647)       lin_sat = 32'sh7fffffff;
    else if (lin_s < -39'sd2147483648) lin_sat = 32'sh80000000;
    else                               lin_sat = 32'(lin_s);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      reached_q <= dist2_q < 33'(radius_q);
      lin_out_q <= lin_sat;
      ang_out_q <= 32'(ang_r);
      rev_out_q <= rev2_q;
    end
  end

  assign out_valid_o        = vld_q[LAST];
  assign linear_velocity_o  = lin_out_q;
  assign angular_velocity_o = ang_out_q;
  assign reversing_o        = rev_out_q;
  assign goal_reached_o     = reached_q;

endmodule

// ----- sv/gsc_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// gsc_sqrt_cell
// One bit of a restoring square root, registered.
// ----------------------------------------------------------------------------
module gsc_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [4:0]     idx_i,
  input  gsc_pkg::sqrt_t sqrt_i,
  output gsc_pkg::sqrt_t sqrt_o
);
  import gsc_pkg::*;

  logic [65:0] trial;
  sqrt_t       sqrt_d;
  sqrt_t       sqrt_q;

  // trial subtrahend (2*root + 2^i) * 2^i
  always_comb begin
    trial  = ({34'd0, sqrt_i.root} << ({1'b0, idx_i} + 6'd1))
           + (66'd1 << ({idx_i, 1'b0}));
    sqrt_d = sqrt_i;
    if ({2'b00, sqrt_i.rem} >= trial) begin
      sqrt_d.rem  = sqrt_i.rem - trial[63:0];
      sqrt_d.root = sqrt_i.root | (32'd1 << idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqrt_q <= sqrt_d;
    end
  end

  assign sqrt_o = sqrt_q;

endmodule

// ----- sv/gsc_atan_front.sv -----
// ----------------------------------------------------------------------------
// gsc_atan_front
// Half-plane fold and normalising shift ahead of the CORDIC cells.
// ----------------------------------------------------------------------------
module gsc_atan_front (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  output gsc_pkg::cordic_t   vec_o
);
  import gsc_pkg::*;

  cordic_t     fold_d, fold_q;
  cordic_t     norm_q;
  cordic_t     shft_d, shft_q;
  logic [4:0]  sh_d, sh_q;
  logic [35:0] mag;
  logic [5:0]  msb;

  // fold left half-plane onto the right
  always_comb begin
    fold_d.zero = (x_i == 36'sd0) && (y_i == 36'sd0);
    fold_d.x    = x_i;
    fold_d.y    = y_i;
    fold_d.z    = '0;
    if (x_i < 36'sd0) begin
      fold_d.x = -x_i;
      fold_d.y = -y_i;
      fold_d.z = (y_i >= 36'sd0) ? PI_Q30 : -PI_Q30;
    end
  end

  // leading one of the larger magnitude
  always_comb begin
    mag = fold_q.x | ((fold_q.y < 36'sd0) ? -fold_q.y : fold_q.y);
    msb = 6'd0;
    for (int i = 0; i < 36; i++) begin
      if (mag[i]) msb = 6'(i);
    end
    sh_d = (msb < 6'd30 && mag != 36'd0) ? 5'(6'd30 - msb) : 5'd0;
  end

  // apply shift
  always_comb begin
    shft_d   = norm_q;
    shft_d.x = norm_q.x <<< sh_q;
    shft_d.y = norm_q.y <<< sh_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
      norm_q <= fold_q;
      sh_q   <= sh_d;
      shft_q <= shft_d;
    end
  end

  assign vec_o = shft_q;

endmodule

// ----- sv/gsc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// gsc_cordic_cell
// One vectoring CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module gsc_cordic_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [4:0]       idx_i,
  input  gsc_pkg::cordic_t vec_i,
  output gsc_pkg::cordic_t vec_o
);
  import gsc_pkg::*;

  cordic_t            vec_d, vec_q;
  logic signed [35:0] xs, ys;
  logic signed [34:0] ang;

  // rotate towards the x axis
  always_comb begin
    xs    = vec_i.x >>> idx_i;
    ys    = vec_i.y >>> idx_i;
    ang   = ATAN_Q30[idx_i];
    vec_d = vec_i;
    if (vec_i.y > 36'sd0) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ang;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// ----- sim/goal_seek_checker.sv -----
// ----------------------------------------------------------------------------
// goal_seek_checker
// Watches the pose and command channels, predicts each command set from the
// pose and the current goal settings, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module goal_seek_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] linear_velocity_i,
  input  logic signed [31:0] angular_velocity_i,
  input  logic               reversing_i,
  input  logic               goal_reached_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import gsc_pkg::*;

  typedef struct packed {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic               rev;
    logic               reached;
  } command_t;

  command_t cmd_q[$];

  logic signed [31:0] goal_x_q, goal_y_q;
  logic [15:0]        ang_gain_q, lin_gain_q;
  logic [30:0]        radius_q;

  assign pending_o = cmd_q.size();

  // arithmetic shift right that floors
  function automatic longint floor_shr(longint v, int s);
    floor_shr = v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    round_shr = (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring rotation, angle in Q2.30
  function automatic longint bearing_q30(longint y, longint x);
    longint z, ax, ay, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    while (ax < (longint'(1) << 30) && ay < (longint'(1) << 30)) begin
      x *= 2; y *= 2; ax *= 2; ay *= 2;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic command_t steer_command(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [15:0] qw, logic signed [15:0] qz);
    longint w, s, half, theta, dx, dy, brg, err, ang, lin;
    longint unsigned ax, ay, dist_v;
    int sh;
    logic rev;
    command_t c;
    w = qw;
    if (w > 16384) w = 16384;
    if (w < -16384) w = -16384;
    s = int_root(longint'(16384) * 16384 - w * w);
    half = round_shr(bearing_q30(s, w), 18);
    theta = 2 * half * ((qz > 0) - (qz < 0));
    dx = longint'(goal_x_q) - px;
    dy = longint'(goal_y_q) - py;
    brg = round_shr(bearing_q30(dy, dx), 18);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sh = (ax >= 64'd2147483648 || ay >= 64'd2147483648) ? 1 : 0;
    ax >>= sh;
    ay >>= sh;
    dist_v = int_root(ax * ax + ay * ay) << sh;
    err = brg - theta;
    rev = (err > HALF_PI_Q12) || (err < -HALF_PI_Q12);
    // large heading error folds once by pi
    if (err > HALF_PI_Q12) err -= PI_Q12;
    else if (err < -HALF_PI_Q12) err += PI_Q12;
    ang = round_shr(longint'(ang_gain_q) * err, 8);
    lin = round_shr(longint'(lin_gain_q) * longint'(dist_v), 12);
    if (rev) lin = -lin;
    c.lin = clip32(lin);
    c.ang = clip32(ang);
    c.rev = rev;
    c.reached = dist_v < radius_q;
    return c;
  endfunction

  // settings mirror, predict on pose transfer, compare on command transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    command_t exp_c;
    if (!rst_ni) begin
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      ang_gain_q   <= 16'd2662;
      lin_gain_q   <= 16'd410;
      radius_q     <= 31'd6554;
      fail_count_o <= 0;
      cmd_q.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        cmd_q.insert(cmd_q.size(), steer_command(pos_x_i, pos_y_i, quat_w_i, quat_z_i));
      if (out_valid_i && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          $error("command transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = cmd_q.pop_front();
          if (exp_c.lin !== linear_velocity_i || exp_c.ang !== angular_velocity_i ||
              exp_c.rev !== reversing_i || exp_c.reached !== goal_reached_i) begin
            if (exp_c.lin !== linear_velocity_i)
              $error("linear_velocity expected %0d got %0d", exp_c.lin, linear_velocity_i);
            if (exp_c.ang !== angular_velocity_i)
              $error("angular_velocity expected %0d got %0d", exp_c.ang, angular_velocity_i);
            if (exp_c.rev !== reversing_i)
              $error("reversing expected %0b got %0b", exp_c.rev, reversing_i);
            if (exp_c.reached !== goal_reached_i)
              $error("goal_reached expected %0b got %0b", exp_c.reached, goal_reached_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_GOAL_X:       goal_x_q   <= cfg_data_i;
          REG_GOAL_Y:       goal_y_q   <= cfg_data_i;
          REG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i[15:0];
          REG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i[15:0];
          REG_GOAL_RADIUS:  radius_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/unicycle_goal_seek_controller_unit_test.sv -----
// ----------------------------------------------------------------------------
// unicycle_goal_seek_controller_unit_test
// Drives directed and random poses through several goal and gain settings,
// with random gaps and a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unicycle_goal_seek_controller_unit_test;
  import gsc_pkg::*;

  localparam int LATENCY   = 39;
  localparam int MAX_CYCLE = 400000;

  logic               clk_i, rst_ni;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y, lin_vel, ang_vel;
  logic signed [15:0] quat_w, quat_z;
  logic               rev, reached;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [31:0]        cfg_data;
  int                 fail_count, pending;
  int                 cycle_count;
  bit                 hold_off;

  unicycle_goal_seek_controller_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .quat_w_i(quat_w), .quat_z_i(quat_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .linear_velocity_o(lin_vel), .angular_velocity_o(ang_vel),
    .reversing_o(rev), .goal_reached_o(reached),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  goal_seek_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .quat_w_i(quat_w), .quat_z_i(quat_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .linear_velocity_i(lin_vel), .angular_velocity_i(ang_vel),
    .reversing_i(rev), .goal_reached_i(reached),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= MAX_CYCLE) begin
        $display("unicycle_goal_seek_controller_unit verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0 || cycle_count % 2000 < 600) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_pose(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [15:0] w, logic signed [15:0] z, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    quat_w   <= w;
    quat_z   <= z;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // wait until every accepted pose has left as a command transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_quat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());
    if (r == 1) return 16'sd0;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic signed [31:0] rand_pos(logic signed [31:0] goal);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom();
    if (r < 4) return goal + $signed($urandom_range(0, 20000)) - 10000;
    return goal + $signed($urandom_range(0, 2000000)) - 1000000;
  endfunction

  initial begin
    logic signed [31:0] gx, gy;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    pos_x    = '0;
    pos_y    = '0;
    quat_w   = '0;
    quat_z   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_GOAL_X;
    cfg_data = '0;
    hold_off = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed poses at reset settings: extremes, pose on goal, zero z, w clamp
    send_pose(0, 0, 16384, 0, 0);
    send_pose(0, 0, -16384, 1, 0);
    send_pose(32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 0);
    send_pose(32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 0);
    send_pose(32'sh80000000, 32'sh7fffffff, 0, -1, 0);
    send_pose(32'sh7fffffff, 0, 11585, 11585, 0);
    send_pose(-65536, 0, 16384, 0, 0);
    send_pose(65536, 0, 0, 16384, 0);
    send_pose(0, 65536, -11585, -11585, 0);
    send_pose(0, -6553, 16384, 0, 0);
    send_pose(0, -6554, 16384, 0, 0);
    send_pose(32'sh55555555, 32'shaaaaaaaa, 16'sh5555, 16'shaaaa, 0);
    send_pose(32'shaaaaaaaa, 32'sh55555555, 16'sh2aaa, 16'sh5555, 0);
    drain();

    // extreme settings so that the linear output saturates
    write_reg(REG_GOAL_X, 32'h7fffffff);
    write_reg(REG_GOAL_Y, 32'h80000000);
    write_reg(REG_ANGULAR_GAIN, 32'h0000ffff);
    write_reg(REG_LINEAR_GAIN, 32'h0000ffff);
    write_reg(REG_GOAL_RADIUS, 32'h7fffffff);
    send_pose(32'sh80000000, 32'sh7fffffff, -16384, 1, 0);
    send_pose(32'sh80000000, 32'sh7fffffff, 16384, 0, 0);
    send_pose(0, 0, 0, -16384, 0);
    send_pose(32'sh7fffffff, 32'sh80000000, 0, 16384, 0);
    drain();

    // random phases over changing settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin gx = 0; gy = 0; end
        1: begin gx = 32'h00030000; gy = 32'hfffb0000; end
        default: begin gx = $urandom(); gy = $urandom(); end
      endcase
      write_reg(REG_GOAL_X, gx);
      write_reg(REG_GOAL_Y, gy);
      write_reg(REG_ANGULAR_GAIN, ph == 3 ? 32'd0 : $urandom_range(0, 65535));
      write_reg(REG_LINEAR_GAIN, ph == 3 ? 32'd0 : $urandom_range(0, 65535));
      write_reg(REG_GOAL_RADIUS, ph == 4 ? 32'd0 : $urandom_range(0, 2000000));
      if (ph == 1) hold_off = 1'b1;
      for (int n = 0; n < 100; n++)
        send_pose(rand_pos(gx), rand_pos(gy), rand_quat(), rand_quat(), 1);
      drain();
    end

    if (fail_count == 0)
      $display("unicycle_goal_seek_controller_unit verification clean");
    else
      $display("unicycle_goal_seek_controller_unit verification failed");
    $finish;
  end

endmodule
